### src/two_value_multimap_table_core_assert.svh
// Assertion macros used by the multimap table scan sequencer.
`ifndef TWO_VALUE_MULTIMAP_TABLE_CORE_ASSERT_SVH
`define TWO_VALUE_MULTIMAP_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define TVMM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define TVMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TVMM_ASSERT(lbl, clk, rst, prop, msg)

`define TVMM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

### src/tvmm_pkg.sv
// Shared types and constants of the two-value multimap table.
`default_nettype none

package tvmm_pkg;

  localparam int KEY_W    = 32;
  localparam int CNT_W    = 7;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  localparam logic [FOUND_W-1:0] MAX_PER_KEY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NULL     = 1'd1;

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;
  localparam int CAP_LIMIT = 127;

  typedef struct packed {
    logic shift;
    logic wr_en;
  } chain_ctl_t;

endpackage

`default_nettype wire

### src/two_value_multimap_table_core.sv
// Two-value multimap table: a ring of entry cells scanned by a sequencer.
//
// Input channel: in_valid with in_stall; an operation (add, search or remove)
// transfers when in_valid is high and in_stall is low. Output channel:
// out_valid with out_stall; one result transfers per operation.
// The entries sit in a ring of ENTRIES cells that rotates by one cell in each
// scan cycle, so every stored entry passes the head compare once per scan.
// After its transfer, an operation is scanned over one full revolution of the
// ring; the done state then writes the table back and registers the result,
// and the block returns to idle. It holds in_stall high while it works, so it
// takes no new operation until the last one has left the done state.
// A result that is stalled stays in the output register; the next operation
// can still be taken and scanned, and it waits only at write-back.
// Configuration writes (capacity, null value) use cfg_valid with cfg_ready
// (always high) and must be made while the block is idle; no logic enforces it.
// Reset empties the table at once, restores capacity 64 and null value 0.
`default_nettype none

module two_value_multimap_table_core
  import tvmm_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      opcode,
  input  wire logic [KEY_W-1:0]     key,
  input  wire logic [KEY_W-1:0]     value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [STATUS_W-1:0]  status,
  output logic      [KEY_W-1:0]     first_value,
  output logic      [KEY_W-1:0]     second_value,
  output logic      [FOUND_W-1:0]   found_count,
  output logic      [CNT_W-1:0]     entries_used
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  chain_ctl_t       ctl;
  logic [IDX_W-1:0] wr_idx;
  logic [KEY_W-1:0] wr_key;
  logic [KEY_W-1:0] wr_value;
  logic [KEY_W-1:0] cell_key   [ENTRIES];
  logic [KEY_W-1:0] cell_value [ENTRIES];

  tvmm_ctrl #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .key          (key),
    .value        (value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .head_key     (cell_key[0]),
    .head_value   (cell_value[0]),
    .ctl          (ctl),
    .wr_idx       (wr_idx),
    .wr_key       (wr_key),
    .wr_value     (wr_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .first_value  (first_value),
    .second_value (second_value),
    .found_count  (found_count),
    .entries_used (entries_used)
  );

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    tvmm_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_idx     (wr_idx),
      .wr_key     (wr_key),
      .wr_value   (wr_value),
      .next_key   (cell_key[(k + 1) % ENTRIES]),
      .next_value (cell_value[(k + 1) % ENTRIES]),
      .cell_key   (cell_key[k]),
      .cell_value (cell_value[k])
    );
  end

endmodule

`default_nettype wire

### src/tvmm_cell.sv
// One storage cell of the entry ring: holds a key and a value.
`default_nettype none

module tvmm_cell
  import tvmm_pkg::*;
#(
  parameter int IDX_W    = 6,
  parameter int CELL_IDX = 0
) (
  input  wire logic             clk,
  input  wire chain_ctl_t       ctl,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire logic [KEY_W-1:0] wr_key,
  input  wire logic [KEY_W-1:0] wr_value,
  input  wire logic [KEY_W-1:0] next_key,
  input  wire logic [KEY_W-1:0] next_value,
  output logic      [KEY_W-1:0] cell_key,
  output logic      [KEY_W-1:0] cell_value
);

  logic wr_sel;

  assign wr_sel = ctl.wr_en && (wr_idx == IDX_W'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      cell_key   <= wr_key;
      cell_value <= wr_value;
    end else if (ctl.shift) begin
      cell_key   <= next_key;
      cell_value <= next_value;
    end
  end

endmodule

`default_nettype wire

### src/tvmm_ctrl.sv
// Scan sequencer: compares the ring head, keeps the count and builds results.
`default_nettype none

`include "two_value_multimap_table_core_assert.svh"

module tvmm_ctrl
  import tvmm_pkg::*;
#(
  parameter int ENTRIES = 64,
  parameter int IDX_W   = 6
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [OP_W-1:0]      opcode,
  input  wire logic [KEY_W-1:0]     key,
  input  wire logic [KEY_W-1:0]     value,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data,
  input  wire logic [KEY_W-1:0]     head_key,
  input  wire logic [KEY_W-1:0]     head_value,
  output chain_ctl_t                ctl,
  output logic      [IDX_W-1:0]     wr_idx,
  output logic      [KEY_W-1:0]     wr_key,
  output logic      [KEY_W-1:0]     wr_value,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [STATUS_W-1:0]  status,
  output logic      [KEY_W-1:0]     first_value,
  output logic      [KEY_W-1:0]     second_value,
  output logic      [FOUND_W-1:0]   found_count,
  output logic      [CNT_W-1:0]     entries_used
);

  localparam int CMP_W   = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int CAP_MAX = (ENTRIES > CAP_LIMIT) ? CAP_LIMIT : ENTRIES;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DONE
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  capacity_in_use;
  logic [KEY_W-1:0]  null_value;
  logic [CNT_W-1:0]  count;
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  op_key;
  logic [KEY_W-1:0]  op_value;
  logic [IDX_W-1:0]  scan_idx;
  logic [FOUND_W-1:0] hits;
  logic [KEY_W-1:0]  first_cap;
  logic [KEY_W-1:0]  second_cap;
  logic              rm_found;
  logic [IDX_W-1:0]  rm_idx;
  logic [KEY_W-1:0]  last_key;
  logic [KEY_W-1:0]  last_value;

  logic              in_range;
  logic              is_last;
  logic              key_hit;
  logic              pair_hit;
  logic [CNT_W-1:0]  eff_cap;
  logic              full;
  logic              load;
  logic              add_ok;
  logic [CNT_W-1:0]  count_next;
  logic [STATUS_W-1:0] status_next;
  logic [KEY_W-1:0]  first_next;
  logic [KEY_W-1:0]  second_next;
  logic [FOUND_W-1:0] found_next;

  assign in_stall  = (state != IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    in_range = CMP_W'(scan_idx) < CMP_W'(count);
    is_last  = (CMP_W'(scan_idx) + CMP_W'(1)) == CMP_W'(count);
    key_hit  = (head_key == op_key);
    pair_hit = key_hit && (head_value == op_value);

    if (capacity_in_use == '0) begin
      eff_cap = CNT_W'(1);
    end else if (CMP_W'(capacity_in_use) > CMP_W'(CAP_MAX)) begin
      eff_cap = CNT_W'(CAP_MAX);
    end else begin
      eff_cap = capacity_in_use;
    end
    full   = (count >= eff_cap);
    add_ok = !full && (hits != MAX_PER_KEY);
    load   = !out_valid || !out_stall;

    status_next = ST_MISS;
    first_next  = '0;
    second_next = '0;
    found_next  = '0;
    count_next  = count;
    unique case (op_q)
      OP_ADD: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (add_ok) begin
          status_next = ST_OK;
          count_next  = count + CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        status_next = ST_OK;
        first_next  = (hits != '0) ? first_cap : null_value;
        second_next = (hits == MAX_PER_KEY) ? second_cap : null_value;
        found_next  = hits;
      end
      OP_REMOVE: begin
        if (rm_found) begin
          status_next = ST_OK;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_MISS;
      end
    endcase

    ctl.shift = (state == SCAN);
    ctl.wr_en = (state == DONE) && load &&
                (((op_q == OP_ADD) && add_ok) || ((op_q == OP_REMOVE) && rm_found));
    if (op_q == OP_ADD) begin
      wr_idx   = IDX_W'(count);
      wr_key   = op_key;
      wr_value = op_value;
    end else begin
      wr_idx   = rm_idx;
      wr_key   = last_key;
      wr_value = last_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      out_valid       <= 1'b0;
      count           <= '0;
      capacity_in_use <= CAP_RESET;
      null_value      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CAPACITY: capacity_in_use <= cfg_data[CNT_W-1:0];
          REG_NULL:     null_value      <= cfg_data;
          default:      null_value      <= null_value;
        endcase
      end
      if (out_valid && !out_stall && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            op_q     <= opcode;
            op_key   <= key;
            op_value <= value;
            scan_idx <= '0;
            hits     <= '0;
            rm_found <= 1'b0;
            rm_idx   <= '0;
            state    <= SCAN;
          end
        end
        SCAN: begin
          if (in_range && key_hit && (hits != MAX_PER_KEY)) begin
            if (hits == '0) begin
              first_cap <= head_value;
            end else begin
              second_cap <= head_value;
            end
            hits <= hits + FOUND_W'(1);
          end
          if (in_range && pair_hit && !rm_found) begin
            rm_found <= 1'b1;
            rm_idx   <= scan_idx;
          end
          if (is_last) begin
            last_key   <= head_key;
            last_value <= head_value;
          end
          scan_idx <= scan_idx + IDX_W'(1);
          if (scan_idx == LAST_IDX) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (load) begin
            out_valid    <= 1'b1;
            status       <= status_next;
            first_value  <= first_next;
            second_value <= second_next;
            found_count  <= found_next;
            entries_used <= count_next;
            count        <= count_next;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  `TVMM_ASSERT(a_count_bound, clk, rst, CMP_W'(count) <= CMP_W'(CAP_MAX), "count above limit")
  `TVMM_ASSERT_NEXT(a_scan_end, clk, rst,
                    (state == SCAN) && (scan_idx == LAST_IDX),
                    state == DONE, "scan did not end")
  `TVMM_ASSERT_NEXT(a_count_hold, clk, rst, state == SCAN, $stable(count), "count moved in scan")
  `TVMM_ASSERT(a_write_op, clk, rst,
               !ctl.wr_en || op_q == OP_ADD || op_q == OP_REMOVE, "bad write")

endmodule

`default_nettype wire
